### hw/rtl/rmj_pkg.sv
// Shared types and constants for the radar measurement Jacobian.
// Used by rmj_div and radar_measurement_jacobian; depends on nothing else.
`default_nettype none
package rmj_pkg;

	// Quotient width and output limits (signed Q31.16).
	localparam int QW = 48;
	localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW-1){1'b0}}};

	// Divider datapath: numerator up to 112 bits, divisor up to 96 bits.
	localparam int DIV_NW = 112;
	localparam int DIV_DW = 96;
	localparam int DIV_STEPS = QW;
	// Entry stage, one stage per quotient bit, output stage.
	localparam int DIV_LAT = DIV_STEPS + 2;

	// Root stages, one result bit each.
	localparam int SQ_STEPS = 32;

	// Register index of the floor register.
	localparam logic REG_FLOOR = 1'b0;

	// Per-item values that travel through the root pipeline.
	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic        nx;
		logic        ny;
		logic [63:0] s;
		logic [63:0] dm;
		logic        nd;
	} ctx_t;

endpackage
`default_nettype wire

### hw/rtl/radar_measurement_jacobian.sv
// done strobes a result once its item has passed stages 1 to 3, the square root, m1,
// m2 and the dividers. Throughput: one item per cycle; busy stays low. The depth is
// set by the 32-stage square root and the 48-stage dividers, one bit per stage.
// Reset clears all valid bits and sets the floor register to 7.
// Top level of the radar measurement Jacobian; depends on rmj_pkg and rmj_div.
`default_nettype none
module radar_measurement_jacobian (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	output logic                    done,
	output logic signed [47:0]      range_dx,
	output logic signed [47:0]      range_dy,
	output logic signed [47:0]      bearing_dx,
	output logic signed [47:0]      bearing_dy,
	output logic signed [47:0]      rate_dx,
	output logic signed [47:0]      rate_dy,
	output logic                    clamped,
	output logic                    saturated,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import rmj_pkg::*;

	localparam int LAT = 3 + SQ_STEPS + 2 + DIV_LAT;

	// Configuration register.
	logic [15:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 16'd7;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FLOOR) begin
			floor_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FLOOR) ? {16'b0, floor_q} : 32'b0;
	assign busy   = 1'b0;

	// Stage 1: sign and magnitude of each input.
	logic        v_s1;
	logic [31:0] px_s1, py_s1, vx_s1, vy_s1;
	logic        nx_s1, ny_s1, nvx_s1, nvy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		nx_s1  <= pos_x[31];
		ny_s1  <= pos_y[31];
		nvx_s1 <= vel_x[31];
		nvy_s1 <= vel_y[31];
		px_s1  <= pos_x[31] ? 32'(-pos_x) : 32'(pos_x);
		py_s1  <= pos_y[31] ? 32'(-pos_y) : 32'(pos_y);
		vx_s1  <= vel_x[31] ? 32'(-vel_x) : 32'(vel_x);
		vy_s1  <= vel_y[31] ? 32'(-vel_y) : 32'(vel_y);
	end

	// Stage 2: squares and cross products.
	logic        v_s2;
	logic [63:0] pxx_s2, pyy_s2, a_s2, b_s2;
	logic [31:0] px_s2, py_s2;
	logic        nx_s2, ny_s2, nvx_s2, nvy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pxx_s2 <= px_s1 * px_s1;
		pyy_s2 <= py_s1 * py_s1;
		a_s2   <= py_s1 * vx_s1;
		b_s2   <= px_s1 * vy_s1;
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		nx_s2  <= nx_s1;
		ny_s2  <= ny_s1;
		nvx_s2 <= nvx_s1;
		nvy_s2 <= nvy_s1;
	end

	// Stage 3: r squared and py*vx - px*vy in sign-magnitude form.
	logic        na, nb;
	logic [63:0] dm_c;
	logic        nd_c;

	always_comb begin
		na = (nvx_s2 ^ ny_s2) && (a_s2 != '0);
		nb = !(nvy_s2 ^ nx_s2) && (b_s2 != '0);
		if (na == nb) begin
			dm_c = a_s2 + b_s2;
			nd_c = na;
		end else if (a_s2 >= b_s2) begin
			dm_c = a_s2 - b_s2;
			nd_c = na;
		end else begin
			dm_c = b_s2 - a_s2;
			nd_c = nb;
		end
	end

	logic        sq_v    [0:SQ_STEPS];
	ctx_t        sq_ctx  [0:SQ_STEPS];
	logic [33:0] sq_rem  [0:SQ_STEPS];
	logic [31:0] sq_root [0:SQ_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_ctx[0].px <= px_s2;
		sq_ctx[0].py <= py_s2;
		sq_ctx[0].nx <= nx_s2;
		sq_ctx[0].ny <= ny_s2;
		sq_ctx[0].s  <= pxx_s2 + pyy_s2;
		sq_ctx[0].dm <= dm_c;
		sq_ctx[0].nd <= nd_c;
		sq_rem[0]    <= '0;
		sq_root[0]   <= '0;
	end

	// Square root: each stage brings down two radicand bits and settles one root bit.
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		logic [35:0] t;
		logic [35:0] trial;
		logic        ge;

		assign t     = {sq_rem[j], sq_ctx[j].s[63-2*j -: 2]};
		assign trial = 36'({sq_root[j], 2'b01});
		assign ge    = (t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j+1] <= 1'b0;
			end else begin
				sq_v[j+1] <= sq_v[j];
			end
		end

		always_ff @(posedge clk) begin
			sq_ctx[j+1]  <= sq_ctx[j];
			sq_rem[j+1]  <= ge ? 34'(t - trial) : 34'(t);
			sq_root[j+1] <= {sq_root[j][30:0], ge};
		end
	end

	// Stage m1: floor compare and 32x32 partial products of r*r^2 and the rate numerators.
	logic        v_m1, clamp_m1;
	ctx_t        ctx_m1;
	logic [31:0] r_m1;
	logic [63:0] rs_lo_m1, rs_hi_m1, yd_lo_m1, yd_hi_m1, xd_lo_m1, xd_hi_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else begin
			v_m1 <= sq_v[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		ctx_m1   <= sq_ctx[SQ_STEPS];
		r_m1     <= sq_root[SQ_STEPS];
		clamp_m1 <= (sq_root[SQ_STEPS] < {16'b0, floor_q});
		rs_lo_m1 <= sq_root[SQ_STEPS] * sq_ctx[SQ_STEPS].s[31:0];
		rs_hi_m1 <= sq_root[SQ_STEPS] * sq_ctx[SQ_STEPS].s[63:32];
		yd_lo_m1 <= sq_ctx[SQ_STEPS].py * sq_ctx[SQ_STEPS].dm[31:0];
		yd_hi_m1 <= sq_ctx[SQ_STEPS].py * sq_ctx[SQ_STEPS].dm[63:32];
		xd_lo_m1 <= sq_ctx[SQ_STEPS].px * sq_ctx[SQ_STEPS].dm[31:0];
		xd_hi_m1 <= sq_ctx[SQ_STEPS].px * sq_ctx[SQ_STEPS].dm[63:32];
	end

	// Stage m2: sum the partial products.
	logic        v_m2, clamp_m2;
	ctx_t        ctx_m2;
	logic [31:0] r_m2;
	logic [95:0] rs_m2, yd_m2, xd_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m2 <= 1'b0;
		end else begin
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_m2   <= ctx_m1;
		r_m2     <= r_m1;
		clamp_m2 <= clamp_m1;
		rs_m2    <= 96'(rs_lo_m1) + {rs_hi_m1, 32'b0};
		yd_m2    <= 96'(yd_lo_m1) + {yd_hi_m1, 32'b0};
		xd_m2    <= 96'(xd_lo_m1) + {xd_hi_m1, 32'b0};
	end

	// Divider operands. Under the floor, r and r^2 become floor_q and r^3 floor_q * 2^16.
	logic [DIV_DW-1:0] d_r, d_r2, d_r3;
	logic [DIV_NW-1:0] n_x1, n_y1, n_x2, n_y2, n_x3, n_y3;

	always_comb begin
		d_r  = clamp_m2 ? DIV_DW'(floor_q) : DIV_DW'(r_m2);
		d_r2 = clamp_m2 ? DIV_DW'(floor_q) : DIV_DW'(ctx_m2.s);
		d_r3 = clamp_m2 ? DIV_DW'({floor_q, 16'b0}) : rs_m2;
		n_x1 = DIV_NW'({ctx_m2.px, 16'b0});
		n_y1 = DIV_NW'({ctx_m2.py, 16'b0});
		n_x2 = clamp_m2 ? DIV_NW'({ctx_m2.px, 16'b0}) : DIV_NW'({ctx_m2.px, 32'b0});
		n_y2 = clamp_m2 ? DIV_NW'({ctx_m2.py, 16'b0}) : DIV_NW'({ctx_m2.py, 32'b0});
		n_x3 = clamp_m2 ? DIV_NW'(xd_m2) : DIV_NW'({xd_m2, 16'b0});
		n_y3 = clamp_m2 ? DIV_NW'(yd_m2) : DIV_NW'({yd_m2, 16'b0});
	end

	logic [5:0]    dv;
	logic [5:0]    ds;
	logic [QW-1:0] q0, q1, q2, q3, q4, q5;

	rmj_div u_div_rx (
		.clk(clk), .arst_n(arst_n), .in_valid(v_m2), .num(n_x1), .den(d_r),
		.neg(ctx_m2.nx), .out_valid(dv[0]), .quo(q0), .sat(ds[0])
	);
	rmj_div u_div_ry (
		.clk(clk), .arst_n(arst_n), .in_valid(v_m2), .num(n_y1), .den(d_r),
		.neg(ctx_m2.ny), .out_valid(dv[1]), .quo(q1), .sat(ds[1])
	);
	rmj_div u_div_bx (
		.clk(clk), .arst_n(arst_n), .in_valid(v_m2), .num(n_y2), .den(d_r2),
		.neg(!ctx_m2.ny), .out_valid(dv[2]), .quo(q2), .sat(ds[2])
	);
	rmj_div u_div_by (
		.clk(clk), .arst_n(arst_n), .in_valid(v_m2), .num(n_x2), .den(d_r2),
		.neg(ctx_m2.nx), .out_valid(dv[3]), .quo(q3), .sat(ds[3])
	);
	rmj_div u_div_vx (
		.clk(clk), .arst_n(arst_n), .in_valid(v_m2), .num(n_y3), .den(d_r3),
		.neg(ctx_m2.ny ^ ctx_m2.nd), .out_valid(dv[4]), .quo(q4), .sat(ds[4])
	);
	rmj_div u_div_vy (
		.clk(clk), .arst_n(arst_n), .in_valid(v_m2), .num(n_x3), .den(d_r3),
		.neg(ctx_m2.nx ^ !ctx_m2.nd), .out_valid(dv[5]), .quo(q5), .sat(ds[5])
	);

	// The clamp flag follows the item alongside the dividers.
	logic cl_q [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		cl_q[0] <= clamp_m2;
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_cl
		always_ff @(posedge clk) begin
			cl_q[k] <= cl_q[k-1];
		end
	end

	assign done       = dv[0];
	assign range_dx   = q0;
	assign range_dy   = q1;
	assign bearing_dx = q2;
	assign bearing_dy = q3;
	assign rate_dx    = q4;
	assign rate_dy    = q5;
	assign clamped    = cl_q[DIV_LAT-1] && dv[0];
	assign saturated  = (|ds) && dv[0];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item did not produce a result at the expected latency");

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		dv[0] |-> (dv[1] && dv[2] && dv[3] && dv[4] && dv[5]))
		else $error("divider lanes out of step");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(clamped || saturated) |-> done)
		else $error("flag raised without a result");

endmodule
`default_nettype wire

### hw/rtl/rmj_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed 48-bit saturated result.
// Depends on rmj_pkg.
`default_nettype none
module rmj_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [rmj_pkg::DIV_NW-1:0] num,
	input  wire logic [rmj_pkg::DIV_DW-1:0] den,
	input  wire logic                       neg,
	output logic                            out_valid,
	output logic [rmj_pkg::QW-1:0]          quo,
	output logic                            sat
);
	import rmj_pkg::*;

	logic              v_s    [0:DIV_STEPS];
	logic [DIV_DW-1:0] rem_s  [0:DIV_STEPS];
	logic [QW-1:0]     low_s  [0:DIV_STEPS];
	logic [QW-1:0]     q_s    [0:DIV_STEPS];
	logic [DIV_DW-1:0] den_s  [0:DIV_STEPS];
	logic              neg_s  [0:DIV_STEPS];
	logic              zero_s [0:DIV_STEPS];
	logic              ovf_s  [0:DIV_STEPS];

	logic [QW-1:0] val;
	logic          val_sat;

	// Entry: a quotient of 2^48 or more always saturates, so only 48 bits are developed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= DIV_DW'(num[DIV_NW-1:QW]);
		low_s[0]  <= num[QW-1:0];
		q_s[0]    <= '0;
		den_s[0]  <= den;
		neg_s[0]  <= neg;
		zero_s[0] <= (den == '0);
		ovf_s[0]  <= ((DIV_DW+QW)'(num) >= {den, {QW{1'b0}}});
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DIV_DW:0] t;
		logic [DIV_DW:0] d;

		assign t = {rem_s[k], low_s[k][QW-1]};
		assign d = t - {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= d[DIV_DW] ? t[DIV_DW-1:0] : d[DIV_DW-1:0];
			q_s[k+1]    <= {q_s[k][QW-2:0], ~d[DIV_DW]};
			low_s[k+1]  <= {low_s[k][QW-2:0], 1'b0};
			den_s[k+1]  <= den_s[k];
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
			ovf_s[k+1]  <= ovf_s[k];
		end
	end

	always_comb begin
		val     = '0;
		val_sat = 1'b0;
		if (zero_s[DIV_STEPS]) begin
			val = '0;
		end else if (ovf_s[DIV_STEPS]) begin
			val_sat = 1'b1;
			val     = neg_s[DIV_STEPS] ? NEG_LIM : POS_LIM;
		end else if (neg_s[DIV_STEPS]) begin
			if (q_s[DIV_STEPS] > NEG_LIM) begin
				val_sat = 1'b1;
				val     = NEG_LIM;
			end else begin
				val = '0 - q_s[DIV_STEPS];
			end
		end else if (q_s[DIV_STEPS][QW-1]) begin
			val_sat = 1'b1;
			val     = POS_LIM;
		end else begin
			val = q_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		quo <= val;
		sat <= val_sat;
	end

endmodule
`default_nettype wire

### tb/tb_radar_measurement_jacobian.sv
// Self-checking testbench for radar_measurement_jacobian: directed and random state vectors.
// Each result is checked against a behavioral Jacobian calculator; depends on rmj_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_radar_measurement_jacobian;
	import rmj_pkg::*;

	typedef struct packed {
		logic signed [47:0] rdx, rdy, bdx, bdy, vdx, vdy;
		logic               clmp, sat;
	} jac_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire busy, done, clamped, saturated, pready;
	wire signed [47:0] range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy;
	wire [31:0] prdata;

	radar_measurement_jacobian dut (.*);

	always #5 clk = ~clk;

	logic [15:0] floor_reg = 16'd7;
	jac_t jac_queue[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0;

	// Exact calculator: quotients truncate toward zero and saturate to 48 bits.
	function automatic logic [47:0] div_sat(input logic neg, input logic [127:0] n,
		input logic [127:0] d, inout logic sat);
		logic [127:0] q;
		if (d == 0) return '0;
		q = n / d;
		if (neg) begin
			if (q > 128'h800000000000) begin sat = 1'b1; return NEG_LIM; end
			return 48'(-q);
		end
		if (q > 128'h7FFFFFFFFFFF) begin sat = 1'b1; return POS_LIM; end
		return q[47:0];
	endfunction

	function automatic jac_t jacobian(input logic signed [31:0] x, y, u, v);
		logic nx, ny, nu, nv, na, nb, nd, sat, clmp;
		logic [127:0] px, py, vx, vy, s, r, a, b, dm, d1, d2, d3, n3y, n3x;
		jac_t o;
		nx = x[31]; ny = y[31]; nu = u[31]; nv = v[31];
		px = nx ? 128'(-64'(x)) : 128'(x); py = ny ? 128'(-64'(y)) : 128'(y);
		vx = nu ? 128'(-64'(u)) : 128'(u); vy = nv ? 128'(-64'(v)) : 128'(v);
		s = px * px + py * py;
		r = 0;
		for (int i = 32; i >= 0; i--)
			if ((r | (128'd1 << i)) * (r | (128'd1 << i)) <= s) r |= 128'd1 << i;
		a = py * vx; b = px * vy;
		na = (nu != ny) && a != 0;
		nb = (nv == nx) && b != 0;
		if (na == nb) begin dm = a + b; nd = na; end
		else if (a >= b) begin dm = a - b; nd = na; end
		else begin dm = b - a; nd = nb; end
		sat = 1'b0;
		clmp = r < floor_reg;
		n3y = py * dm; n3x = px * dm;
		if (clmp) begin
			d1 = floor_reg; d2 = floor_reg; d3 = 128'(floor_reg) << 16;
		end else begin
			d1 = r; d2 = s; d3 = r * s; n3y = n3y << 16; n3x = n3x << 16;
		end
		o.rdx = div_sat(nx, px << 16, d1, sat);
		o.rdy = div_sat(ny, py << 16, d1, sat);
		o.bdx = div_sat(!ny, clmp ? py << 16 : py << 32, d2, sat);
		o.bdy = div_sat(nx, clmp ? px << 16 : px << 32, d2, sat);
		o.vdx = div_sat(ny != nd, n3y, d3, sat);
		o.vdy = div_sat(nx == nd, n3x, d3, sat);
		o.clmp = clmp; o.sat = sat;
		return o;
	endfunction

	always @(posedge clk) begin
		jac_t e, g;
		cycles <= cycles + 1;
		if (done) begin
			g = '{range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy,
				clamped, saturated};
			if (jac_queue.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", g);
			end else begin
				e = jac_queue.pop_front();
				if (e !== g) begin
					errors++;
					if (errors <= 10) $display("mismatch exp %h got %h", e, g);
				end
			end
		end
	end

	task automatic write_floor(input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(REG_FLOOR) << 2; pwdata <= {16'hDEAD, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		floor_reg = val;
	endtask

	// Holds one item on the inputs until it is accepted. Start stays high between
	// back-to-back items and drops only for idle cycles.
	task automatic send(input logic signed [31:0] x, y, u, v, input logic chk,
		input jac_t want);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		start <= 1'b1; pos_x <= x; pos_y <= y; vel_x <= u; vel_y <= v;
		do @(posedge clk); while (busy);
		jac_queue.push_back(jacobian(x, y, u, v));
		if (chk && want !== jac_queue[$]) begin
			errors++;
			if (errors <= 10) $display("table row exp %h calc %h", want, jac_queue[$]);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (jac_queue.size() != 0) @(posedge clk);
		repeat (DIV_LAT + SQ_STEPS + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd32();
		case ($urandom_range(5))
			0: return $urandom_range(255) - 128;
			1: return 32'(int'($urandom_range(20000)) - 10000) <<< 8;
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			3: return $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	typedef struct {
		logic signed [31:0] x, y, u, v;
		logic chk;
		jac_t want;
	} row_t;

	row_t rows[] = '{
		'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, '{48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0,
			48'sd0, 1'b1, 1'b0}},
		'{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b1, '{48'sd65536, 48'sd0, 48'sd0,
			48'sd65536, 48'sd0, 48'sd0, 1'b0, 1'b0}},
		'{32'sd0, 32'sd65536, 32'sd0, 32'sd0, 1'b1, '{48'sd0, 48'sd65536, -48'sd65536,
			48'sd0, 48'sd0, 48'sd0, 1'b0, 1'b0}},
		'{32'sd1, 32'sd1, 32'sd65536, 32'sd0, 1'b0, '0},
		'{32'sd5, -32'sd3, -32'sd65536, 32'sd65536, 1'b0, '0},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0, '0},
		'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b0, '0},
		'{32'h80000000, 32'sd0, 32'sd0, 32'h80000000, 1'b0, '0},
		'{32'sd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'sd0, 1'b0, '0},
		'{-32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536, 1'b0, '0},
		'{32'sd6, 32'sd0, 32'sd100, 32'sd100, 1'b0, '0},
		'{32'sd7, 32'sd0, 32'sd100, -32'sd100, 1'b0, '0},
		'{32'sd100, 32'sd100, 32'sd100, 32'sd100, 1'b0, '0},
		'{32'sd3000, -32'sd4000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, '0}
	};

	initial begin
		int idle_mode[4] = '{0, 81, 0, 20};
		logic [15:0] floors[4] = '{16'd1, 16'hFFFF, 16'd300, 16'd7};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send(rows[i].x, rows[i].y, rows[i].u, rows[i].v, rows[i].chk,
			rows[i].want);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			write_floor(floors[ph]);
			send_idle = idle_mode[ph];
			for (int k = 0; k < 225; k++) begin
				// Near the floor, small positions exercise the clamp boundary.
				if ($urandom_range(3) == 0)
					send(32'($urandom_range(600)) - 300, 32'($urandom_range(600)) - 300,
						rnd32(), rnd32(), 1'b0, '0);
				else
					send(rnd32(), rnd32(), rnd32(), rnd32(), 1'b0, '0);
			end
			drain();
		end
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		wait (cycles >= 400000);
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
